// ===== rtl/differential_drive_odometry_unit_macros.svh =====
// Assertion macros for the differential-drive odometry unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
// Shared types, widths, constants and the arctangent table of the odometry unit.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int SPEED_W     = 16;
    localparam int CFG_W       = 16;
    localparam int POS_W       = 32;
    localparam int HEAD_W      = 16;
    localparam int SUM_W       = 18;
    localparam int MUL_A_W     = 42;
    localparam int MUL_B_W     = 17;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIST_W      = 25;
    localparam int TURN_W      = 34;
    localparam int ANG_W       = 42;
    localparam int CXY_W       = 34;
    localparam int SAT_W       = 34;
    localparam int GSUM_W      = 60;
    localparam int STEP_W      = 64;
    localparam int Z_FRAC      = 16;
    localparam int ADDR_W      = 4;
    localparam int APB_DW      = 32;
    localparam int ANGLE_IDX_W = 5;

    localparam int CORDIC_STEPS_DEF = 16;

    // Register reset values.
    localparam logic [CFG_W-1:0] RADIUS_RST    = 16'd3932;
    localparam logic [CFG_W-1:0] INV_TRACK_RST = 16'd1280;
    localparam logic [CFG_W-1:0] PERIOD_RST    = 16'd655;

    // Register indexes, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_RADIUS    = 2'd0;
    localparam logic [ADDR_W-3:0] REG_INV_TRACK = 2'd1;
    localparam logic [ADDR_W-3:0] REG_PERIOD    = 2'd2;

    // 2^39/pi, radians at 2^-24 to binary angle at 2^-48.
    localparam logic [37:0] BAM_PER_RAD = 38'd174992710548;
    // Inverse CORDIC gain at 2^-30.
    localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

    localparam logic signed [HEAD_W:0] QUARTER_TURN     = 17'sd16384;
    localparam logic signed [HEAD_W:0] NEG_QUARTER_TURN = -17'sd16384;
    localparam logic signed [HEAD_W:0] HALF_TURN        = 17'sd32768;

    typedef struct packed {
        logic [CFG_W-1:0] radius;
        logic [CFG_W-1:0] inv_track;
        logic [CFG_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) with pi equal to 2^31.
    function automatic logic [31:0] atan_lut(input logic [ANGLE_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41721;
            5'd15:   v = 32'd20860;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2607;
            5'd19:   v = 32'd1303;
            5'd20:   v = 32'd651;
            5'd21:   v = 32'd325;
            5'd22:   v = 32'd162;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ddo_regs.sv =====
// APB-style configuration registers: wheel radius, inverse track and tick period.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddo_pkg::APB_DW-1:0]  pwdata,
    output logic [ddo_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output ddo_pkg::cfg_t               cfg
);
    import ddo_pkg::*;

    logic [CFG_W-1:0]  radius_reg;
    logic [CFG_W-1:0]  inv_track_reg;
    logic [CFG_W-1:0]  period_reg;
    logic [ADDR_W-3:0] idx;
    logic              wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= RADIUS_RST;
            inv_track_reg <= INV_TRACK_RST;
            period_reg    <= PERIOD_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_RADIUS:    radius_reg    <= pwdata[CFG_W-1:0];
                REG_INV_TRACK: inv_track_reg <= pwdata[CFG_W-1:0];
                REG_PERIOD:    period_reg    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RADIUS:    prdata = APB_DW'(radius_reg);
            REG_INV_TRACK: prdata = APB_DW'(inv_track_reg);
            REG_PERIOD:    prdata = APB_DW'(period_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.radius    = radius_reg;
    assign cfg.inv_track = inv_track_reg;
    assign cfg.period    = period_reg;

endmodule

// ===== rtl/ddo_mul.sv =====
// Shared signed multiplier with a registered product, one product per cycle.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_mul (
    input  logic                                aclk,
    input  logic signed [ddo_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [ddo_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [ddo_pkg::MUL_P_W-1:0]  prod
);
    import ddo_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/ddo_cordic.sv =====
// Iterative CORDIC rotator: folds the heading into the right half-plane, then
// performs one micro-rotation per cycle. Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [ddo_pkg::CXY_W-1:0]   x_init,
    input  logic signed [ddo_pkg::HEAD_W-1:0]  head,
    output logic signed [ddo_pkg::CXY_W-1:0]   x_out,
    output logic signed [ddo_pkg::CXY_W-1:0]   y_out,
    output ddo_pkg::cordic_stat_t              stat
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    logic signed [CXY_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CXY_W-1:0] x_next, y_next, z_next;
    logic signed [CXY_W-1:0] x_first, z_first;
    logic signed [CXY_W-1:0] xs, ys, atan_v;
    logic signed [HEAD_W:0]  h_ext, h_fold;
    logic                    flip;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    // Headings beyond a quarter turn are rotated by half a turn and the start
    // vector negated, which keeps the angle inside the CORDIC convergence range.
    always_comb begin
        h_ext  = {head[HEAD_W-1], head};
        h_fold = h_ext;
        flip   = 1'b0;
        if (h_ext > QUARTER_TURN) begin
            h_fold = h_ext - HALF_TURN;
            flip   = 1'b1;
        end else if (h_ext < NEG_QUARTER_TURN) begin
            h_fold = h_ext + HALF_TURN;
            flip   = 1'b1;
        end
        x_first = flip ? -x_init : x_init;
        z_first = {{(CXY_W-HEAD_W-1-Z_FRAC){h_fold[HEAD_W]}}, h_fold, {Z_FRAC{1'b0}}};
    end

    always_comb begin
        xs     = x_reg >>> cnt_reg;
        ys     = y_reg >>> cnt_reg;
        atan_v = signed'(CXY_W'(atan_lut(ANGLE_IDX_W'(cnt_reg))));
        if (!z_reg[CXY_W-1]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_v;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x_first;
                y_reg    <= '0;
                z_reg    <= z_first;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/differential_drive_odometry_unit.sv =====
// Top level of the differential-drive odometry unit: sequencer, accumulators
// and handshakes. Depends on ddo_pkg, ddo_regs, ddo_mul, ddo_cordic and the macros.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake          Payload
//  --------  ---------  -----------------  ---------------------------------------------
//  s_*       in         s_valid / s_ready  four signed Q8.8 wheel speeds
//  m_*       out        m_valid / m_ready  pos_x, pos_y, heading, path_length, saturated
//  APB       in/out     psel / penable     wheel_radius, inverse_track, tick_period
//
//  A request is accepted only in the idle state, and the next request can be taken
//  only once the result of the last one has been written to the result registers.
//  The spacing of requests is set by the thirteen-step schedule of the one shared
//  multiplier and by the CORDIC loop, which performs one micro-rotation per cycle.
//  Reset is synchronous and active low; it clears the sequencer, the heading, x, y and
//  path accumulators and the CORDIC control, and restores the register defaults.
//  A result held back by m_ready stalls the unit in its final step until taken.

`include "differential_drive_odometry_unit_macros.svh"

module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ddo_pkg::ADDR_W-1:0]          paddr,
    input  logic [ddo_pkg::APB_DW-1:0]          pwdata,
    output logic [ddo_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    // Wheel speed requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  s_front_right_speed,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  s_rear_right_speed,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  s_front_left_speed,
    input  logic signed [ddo_pkg::SPEED_W-1:0]  s_rear_left_speed,
    // Pose results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ddo_pkg::POS_W-1:0]    m_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0]    m_pos_y,
    output logic signed [ddo_pkg::HEAD_W-1:0]   m_heading,
    output logic signed [ddo_pkg::POS_W-1:0]    m_path_length,
    output logic                                m_saturated
);
    import ddo_pkg::*;

    // Rounding offsets for the right shifts of the schedule: distance by 26,
    // turn rate by 16, heading angle by 9, start vector by 22 and result by 8.
    localparam logic signed [MUL_P_W-1:0] RND_DIST = MUL_P_W'(1) << 25;
    localparam logic signed [MUL_P_W-1:0] RND_TURN = MUL_P_W'(1) << 15;
    localparam logic signed [MUL_P_W-1:0] RND_ANG  = MUL_P_W'(1) << 8;
    localparam logic signed [GSUM_W-1:0]  RND_X0   = GSUM_W'(1) << 21;
    localparam logic signed [CXY_W-1:0]   RND_OUT  = CXY_W'(1) << 7;
    localparam logic [STEP_W-1:0]         RND_STEP = STEP_W'(1) << 47;
    localparam logic signed [SAT_W-1:0]   POS_MAX  = SAT_W'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [SAT_W-1:0]   POS_MIN  = ~POS_MAX;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_SR,
        ST_MUL_ST,
        ST_MUL_DR,
        ST_MUL_DI,
        ST_RND_W,
        ST_MUL_WT,
        ST_RND_A,
        ST_MUL_C0,
        ST_MUL_C1,
        ST_MUL_C2,
        ST_MUL_G0,
        ST_MUL_G1,
        ST_RND_X,
        ST_ROTATE,
        ST_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg;

    cfg_t         cfg;
    cordic_stat_t cstat;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic signed [SUM_W-1:0]   sum_in, dif_in;
    logic signed [SUM_W-1:0]   sum_reg, dif_reg;
    logic signed [DIST_W-1:0]  dist_reg;
    logic signed [TURN_W-1:0]  turn_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic [STEP_W-1:0]         step_acc_reg;
    logic [STEP_W-1:0]         step_fin;
    logic signed [HEAD_W-1:0]  head_new_reg;
    logic signed [GSUM_W-1:0]  gsum_reg;
    logic signed [GSUM_W-1:0]  x0_sum;
    logic signed [CXY_W-1:0]   x0_reg;

    logic signed [MUL_P_W-1:0] dist_sum, turn_sum, ang_sum;

    logic signed [CXY_W-1:0]   cx, cy;
    logic signed [CXY_W-1:0]   dx_sum, dy_sum;
    logic [POS_W:0]            x_sat, y_sat, p_sat;

    logic signed [HEAD_W-1:0]  heading_acc_reg;
    logic signed [POS_W-1:0]   x_acc_reg, y_acc_reg, path_acc_reg;
    logic                      sat_reg;
    logic                      m_valid_reg;
    logic                      cordic_start;

    // Adds a rounded increment to an accumulator and clips it to the 32-bit
    // signed range; the top bit of the result flags a clip.
    function automatic logic [POS_W:0] sat_add(input logic signed [POS_W-1:0] acc,
                                               input logic signed [SAT_W-1:0] delta);
        logic signed [SAT_W-1:0] s;
        s = SAT_W'(acc) + delta;
        if (s > POS_MAX) begin
            return {1'b1, POS_MAX[POS_W-1:0]};
        end else if (s < POS_MIN) begin
            return {1'b1, POS_MIN[POS_W-1:0]};
        end
        return {1'b0, s[POS_W-1:0]};
    endfunction

    ddo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddo_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_init  (x0_reg),
        .head    (head_new_reg),
        .x_out   (cx),
        .y_out   (cy),
        .stat    (cstat)
    );

    // Wheel sums of the request: right pair plus left pair, and their difference.
    assign sum_in = SUM_W'(s_front_right_speed) + SUM_W'(s_rear_right_speed)
                  + SUM_W'(s_front_left_speed) + SUM_W'(s_rear_left_speed);
    assign dif_in = SUM_W'(s_front_right_speed) + SUM_W'(s_rear_right_speed)
                  - SUM_W'(s_front_left_speed) - SUM_W'(s_rear_left_speed);

    // Operand selection for the shared multiplier. The product of the operands
    // chosen in one state is available in the following state.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_SR: begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'(cfg.radius);
            end
            ST_MUL_ST: begin
                mul_a = MUL_A_W'(mul_prod);
                mul_b = MUL_B_W'(cfg.period);
            end
            ST_MUL_DR: begin
                mul_a = MUL_A_W'(dif_reg);
                mul_b = MUL_B_W'(cfg.radius);
            end
            ST_MUL_DI: begin
                mul_a = MUL_A_W'(mul_prod);
                mul_b = MUL_B_W'(cfg.inv_track);
            end
            ST_MUL_WT: begin
                mul_a = MUL_A_W'(turn_reg);
                mul_b = MUL_B_W'(cfg.period);
            end
            ST_MUL_C0: begin
                mul_a = ang_reg;
                mul_b = MUL_B_W'(BAM_PER_RAD[15:0]);
            end
            ST_MUL_C1: begin
                mul_a = ang_reg;
                mul_b = MUL_B_W'(BAM_PER_RAD[31:16]);
            end
            ST_MUL_C2: begin
                mul_a = ang_reg;
                mul_b = MUL_B_W'(BAM_PER_RAD[37:32]);
            end
            ST_MUL_G0: begin
                mul_a = MUL_A_W'(dist_reg);
                mul_b = MUL_B_W'(CORDIC_GAIN[15:0]);
            end
            ST_MUL_G1: begin
                mul_a = MUL_A_W'(dist_reg);
                mul_b = MUL_B_W'(CORDIC_GAIN[29:16]);
            end
            default: ;
        endcase
    end

    // Rounded right shifts of the registered product.
    assign dist_sum = mul_prod + RND_DIST;
    assign turn_sum = mul_prod + RND_TURN;
    assign ang_sum  = mul_prod + RND_ANG;

    // The heading step only needs the low 64 bits of angle times 2^39/pi, so the
    // three partial products are summed modulo 2^64 and bits 63 to 48 taken.
    assign step_fin = step_acc_reg + (STEP_W'(mul_prod) << 32);

    // Start vector: distance times the inverse gain, assembled from two halves.
    assign x0_sum = gsum_reg + (GSUM_W'(mul_prod) <<< 16);

    // Rounded CORDIC outputs and the saturating updates of the three accumulators.
    assign dx_sum = cx + RND_OUT;
    assign dy_sum = cy + RND_OUT;
    assign x_sat  = sat_add(x_acc_reg, dx_sum >>> 8);
    assign y_sat  = sat_add(y_acc_reg, dy_sum >>> 8);
    assign p_sat  = sat_add(path_acc_reg, SAT_W'(dist_reg));

    assign cordic_start = (state_reg == ST_ROTATE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            heading_acc_reg <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            path_acc_reg    <= '0;
            sat_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sum_reg   <= sum_in;
                        dif_reg   <= dif_in;
                        state_reg <= ST_MUL_SR;
                    end
                end
                ST_MUL_SR: state_reg <= ST_MUL_ST;
                ST_MUL_ST: state_reg <= ST_MUL_DR;
                ST_MUL_DR: begin
                    dist_reg  <= DIST_W'(dist_sum >>> 26);
                    state_reg <= ST_MUL_DI;
                end
                ST_MUL_DI: state_reg <= ST_RND_W;
                ST_RND_W: begin
                    turn_reg  <= TURN_W'(turn_sum >>> 16);
                    state_reg <= ST_MUL_WT;
                end
                ST_MUL_WT: state_reg <= ST_RND_A;
                ST_RND_A: begin
                    ang_reg   <= ANG_W'(ang_sum >>> 9);
                    state_reg <= ST_MUL_C0;
                end
                ST_MUL_C0: state_reg <= ST_MUL_C1;
                ST_MUL_C1: begin
                    step_acc_reg <= RND_STEP + STEP_W'(mul_prod);
                    state_reg    <= ST_MUL_C2;
                end
                ST_MUL_C2: begin
                    step_acc_reg <= step_acc_reg + (STEP_W'(mul_prod) << 16);
                    state_reg    <= ST_MUL_G0;
                end
                ST_MUL_G0: begin
                    head_new_reg <= heading_acc_reg + step_fin[STEP_W-1:STEP_W-HEAD_W];
                    state_reg    <= ST_MUL_G1;
                end
                ST_MUL_G1: begin
                    gsum_reg  <= GSUM_W'(mul_prod) + RND_X0;
                    state_reg <= ST_RND_X;
                end
                ST_RND_X: begin
                    x0_reg    <= CXY_W'(x0_sum >>> 22);
                    state_reg <= ST_ROTATE;
                end
                ST_ROTATE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (cstat.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // The accumulators are also the result registers, so they move
                    // only once the previous result has gone.
                    if (!m_valid_reg || m_ready) begin
                        heading_acc_reg <= head_new_reg;
                        x_acc_reg       <= x_sat[POS_W-1:0];
                        y_acc_reg       <= y_sat[POS_W-1:0];
                        path_acc_reg    <= p_sat[POS_W-1:0];
                        sat_reg         <= x_sat[POS_W] | y_sat[POS_W] | p_sat[POS_W];
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pos_x       = x_acc_reg;
    assign m_pos_y       = y_acc_reg;
    assign m_heading     = heading_acc_reg;
    assign m_path_length = path_acc_reg;
    assign m_saturated   = sat_reg;

    // The rotator only runs while the unit is busy with a request.
    `DDO_ASSERT_NOW(a_cordic_busy_blocks, aclk, aresetn, cstat.busy, !s_ready, "request taken while CORDIC busy")
    // An accepted request makes the unit busy at once.
    `DDO_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "unit still ready after accepting a request")
    // The rotator finishes only while the sequencer waits for it.
    `DDO_ASSERT_NOW(a_done_in_wait, aclk, aresetn, cstat.done, state_reg == ST_WAIT, "CORDIC finished outside the wait step")
    // A new result is raised only from the final step of the schedule.
    `DDO_ASSERT_NOW(a_result_from_fin, aclk, aresetn, $rose(m_valid), $past(state_reg) == ST_FIN, "result raised outside the final step")

endmodule

// ===== dv/differential_drive_odometry_unit_tb.sv =====
// Self-checking testbench for the differential-drive odometry unit: directed pose
// ticks and register writes, then randomised ticks under many register settings.
// Depends on ddo_pkg and the differential_drive_odometry_unit RTL.
`timescale 1ns / 1ps

module differential_drive_odometry_unit_tb;

    import ddo_pkg::*;

    localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;

    // The arctangent table holds 24 micro-rotation angles; longer loops stop there.
    localparam int ATAN_TABLE_LEN = 24;
    localparam int ROTATIONS      = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
                                                                    : ATAN_TABLE_LEN;

    // Angles atan(2^-i) with pi equal to 2^31.
    localparam longint ATAN_STEP [ATAN_TABLE_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81
    };

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    // An index that the register map does not decode; writes to it must be dropped.
    localparam logic [ADDR_W-3:0] REG_SPARE = 2'd3;

    localparam int DRAIN_CYCLES   = CORDIC_STEPS + 24;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int SATURATION_TICKS = 400;
    localparam int PHASE_COUNT      = 11;
    localparam int PHASE_TICKS      = 130;

    typedef logic [ADDR_W-3:0] reg_idx_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] front_right;
        logic signed [SPEED_W-1:0] rear_right;
        logic signed [SPEED_W-1:0] front_left;
        logic signed [SPEED_W-1:0] rear_left;
    } wheel_speeds_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  path_length;
        logic                     saturated;
    } pose_t;

    typedef enum logic {
        ROW_WRITE,
        ROW_TICK
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        reg_idx_t      idx;
        logic [31:0]   wdata;
        wheel_speeds_t speeds;
        bit            typed;
        pose_t         pose;
    } script_row_t;

    typedef enum logic [2:0] {
        MIX_RANDOM,
        MIX_STRAIGHT,
        MIX_SPIN,
        MIX_CRAWL,
        MIX_CORNER
    } speed_mix_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_CHOKED
    } ready_mode_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input holds a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [ADDR_W-1:0]         paddr   = '0;
    logic [APB_DW-1:0]         pwdata  = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [SPEED_W-1:0] s_front_right_speed = '0;
    logic signed [SPEED_W-1:0] s_rear_right_speed  = '0;
    logic signed [SPEED_W-1:0] s_front_left_speed  = '0;
    logic signed [SPEED_W-1:0] s_rear_left_speed   = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [POS_W-1:0]   m_pos_x;
    logic signed [POS_W-1:0]   m_pos_y;
    logic signed [HEAD_W-1:0]  m_heading;
    logic signed [POS_W-1:0]   m_path_length;
    logic                      m_saturated;

    always #5 aclk = ~aclk;

    differential_drive_odometry_unit #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_front_right_speed (s_front_right_speed),
        .s_rear_right_speed  (s_rear_right_speed),
        .s_front_left_speed  (s_front_left_speed),
        .s_rear_left_speed   (s_rear_left_speed),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pos_x             (m_pos_x),
        .m_pos_y             (m_pos_y),
        .m_heading           (m_heading),
        .m_path_length       (m_path_length),
        .m_saturated         (m_saturated)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block: the three registers and the four accumulators, all
    // at their reset values. The shadow moves only when a request is accepted
    // or a register write completes.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]        reg_shadow [3] = '{RADIUS_RST, INV_TRACK_RST, PERIOD_RST};
    logic [HEAD_W-1:0]       heading_sum = '0;
    logic signed [POS_W-1:0] x_sum       = '0;
    logic signed [POS_W-1:0] y_sum       = '0;
    logic signed [POS_W-1:0] path_sum    = '0;

    pose_t         pending_poses [$];
    script_row_t   script [$];
    int            fail_count  = 0;
    int            quiet_cycles = 0;
    ready_mode_t   ready_mode  = RDY_ALWAYS;
    int            ready_left  = 0;
    pose_t         oldest_pose;

    // Round to nearest with ties upwards: floor((v + 2^(n-1)) / 2^n).
    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [POS_W-1:0] clip_add(input logic signed [POS_W-1:0] acc,
                                                          input longint delta,
                                                          inout bit clipped);
        longint sum;
        sum = longint'(acc) + delta;
        if (sum > POS_MAX) begin
            clipped = 1'b1;
            return POS_W'(POS_MAX);
        end
        if (sum < POS_MIN) begin
            clipped = 1'b1;
            return POS_W'(POS_MIN);
        end
        return POS_W'(sum);
    endfunction

    // One control tick of the dead-reckoning arithmetic. The heading is moved
    // first, then the travelled distance is rotated onto the new heading.
    function automatic pose_t advance_odometry(input wheel_speeds_t sp);
        longint      right_sum, left_sum, radius, inv_track, period;
        longint      travel, turn, angle, h, cx, cy, cz, xs, ys;
        logic [63:0] angle_bits, bam_prod;
        bit          clipped;
        pose_t       res;

        right_sum = longint'(sp.front_right) + longint'(sp.rear_right);
        left_sum  = longint'(sp.front_left) + longint'(sp.rear_left);
        radius    = longint'(reg_shadow[REG_RADIUS]);
        inv_track = longint'(reg_shadow[REG_INV_TRACK]);
        period    = longint'(reg_shadow[REG_PERIOD]);
        clipped   = 1'b0;

        // Distance at 2^-16 m, turn rate at 2^-17 rad/s, turn angle at 2^-24 rad.
        travel = round_shift((right_sum + left_sum) * radius * period, 26);
        turn   = round_shift((right_sum - left_sum) * radius * inv_track, 16);
        angle  = round_shift(turn * period, 9);

        // Only the low 64 bits of the product are needed, since the step is
        // taken modulo one full turn.
        angle_bits  = angle;
        bam_prod    = angle_bits * 64'(BAM_PER_RAD) + (64'd1 << 47);
        heading_sum = heading_sum + bam_prod[63:48];

        // Fold the heading into the half-plane the rotation converges over.
        h  = longint'($signed(heading_sum));
        cx = round_shift(travel * longint'(CORDIC_GAIN), 22);
        cy = 0;
        if (h > longint'(QUARTER_TURN)) begin
            h  = h - longint'(HALF_TURN);
            cx = -cx;
        end else if (h < longint'(NEG_QUARTER_TURN)) begin
            h  = h + longint'(HALF_TURN);
            cx = -cx;
        end
        cz = h <<< Z_FRAC;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - ATAN_STEP[i];
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + ATAN_STEP[i];
            end
        end

        x_sum    = clip_add(x_sum, round_shift(cx, 8), clipped);
        y_sum    = clip_add(y_sum, round_shift(cy, 8), clipped);
        path_sum = clip_add(path_sum, travel, clipped);

        res.pos_x       = x_sum;
        res.pos_y       = y_sum;
        res.heading     = heading_sum;
        res.path_length = path_sum;
        res.saturated   = clipped;
        return res;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side. A result is sampled at the edge where it is taken, so every
    // value read here is the one held before that edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                $error("pose result with no request outstanding");
                fail_count++;
            end else begin
                oldest_pose = pending_poses.pop_front();
                check_field("pos_x", oldest_pose.pos_x, m_pos_x);
                check_field("pos_y", oldest_pose.pos_y, m_pos_y);
                check_field("heading", oldest_pose.heading, m_heading);
                check_field("path_length", oldest_pose.path_length, m_path_length);
                check_field("saturated", oldest_pose.saturated, m_saturated);
            end
        end
    end

    // The receiver switches between taking everything, a coin toss each cycle
    // and long choked stretches, each mode held for a random number of cycles.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_left = $urandom_range(1, 200);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RDY_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_ready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // The watchdog is rearmed by any request, result or register access.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All drive with nonblocking assignments at a rising edge.
    // ------------------------------------------------------------------------

    // Offer one request and hold it until it is taken; the shadow advances at
    // the accepting edge. A typed pose, where given, stands in for the shadow's.
    task automatic offer_tick(input wheel_speeds_t sp, input bit typed, input pose_t pose);
        pose_t predicted;
        s_valid             <= 1'b1;
        s_front_right_speed <= sp.front_right;
        s_rear_right_speed  <= sp.rear_right;
        s_front_left_speed  <= sp.front_left;
        s_rear_left_speed   <= sp.rear_left;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_odometry(sp);
        pending_poses.push_back(typed ? pose : predicted);
    endtask

    task automatic wait_drained();
        while (pending_poses.size() != 0) @(posedge aclk);
    endtask

    // Setup phase, access phase, then an idle phase so that back-to-back
    // transfers never assign psel twice in one step.
    task automatic apb_transfer(input bit is_write, input reg_idx_t idx,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Only the low half of a write is kept, and unmapped indexes are dropped.
    task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] wdata);
        logic [APB_DW-1:0] unused;
        apb_transfer(1'b1, idx, wdata, unused);
        if (idx <= REG_PERIOD) begin
            reg_shadow[idx] = wdata[CFG_W-1:0];
        end
    endtask

    task automatic verify_registers();
        logic [APB_DW-1:0] rdata;
        for (int i = 0; i <= int'(REG_PERIOD); i++) begin
            apb_transfer(1'b0, reg_idx_t'(i), '0, rdata);
            check_field("prdata", longint'({16'd0, reg_shadow[i]}), longint'(rdata));
        end
    endtask

    // Upper half is random so that the truncation of wide writes is exercised.
    task automatic load_settings(input logic [CFG_W-1:0] radius,
                                 input logic [CFG_W-1:0] inv_track,
                                 input logic [CFG_W-1:0] period);
        write_register(REG_RADIUS, {16'($urandom()), radius});
        write_register(REG_INV_TRACK, {16'($urandom()), inv_track});
        write_register(REG_PERIOD, {16'($urandom()), period});
        verify_registers();
    endtask

    function automatic wheel_speeds_t make_speeds(input int fr, input int rr,
                                                  input int fl, input int rl);
        wheel_speeds_t sp;
        sp.front_right = SPEED_W'(fr);
        sp.rear_right  = SPEED_W'(rr);
        sp.front_left  = SPEED_W'(fl);
        sp.rear_left   = SPEED_W'(rl);
        return sp;
    endfunction

    function automatic pose_t pose_at_origin(input int heading);
        pose_t p;
        p         = '0;
        p.heading = HEAD_W'(heading);
        return p;
    endfunction

    function automatic void add_write(input reg_idx_t idx, input logic [31:0] wdata);
        script_row_t row;
        row       = '{kind: ROW_WRITE, idx: idx, wdata: wdata, speeds: '0,
                      typed: 1'b0, pose: '0};
        script.push_back(row);
    endfunction

    function automatic void add_tick(input wheel_speeds_t sp, input bit typed,
                                     input pose_t pose);
        script_row_t row;
        row       = '{kind: ROW_TICK, idx: '0, wdata: '0, speeds: sp,
                      typed: typed, pose: pose};
        script.push_back(row);
    endfunction

    // A mix of full-range noise, straight runs, spins on the spot, crawling
    // speeds and corner values of the speed range.
    function automatic wheel_speeds_t random_speeds();
        logic signed [SPEED_W-1:0] corners [5] = '{-16'sd32768, -16'sd1, 16'sd0,
                                                   16'sd1, 16'sd32767};
        logic signed [SPEED_W-1:0] v;
        wheel_speeds_t             sp;
        v = SPEED_W'($urandom());
        case (speed_mix_t'($urandom_range(0, 4)))
            MIX_STRAIGHT: begin
                sp = {v, v, v, v};
            end
            MIX_SPIN: begin
                sp = {v, v, -v, -v};
            end
            MIX_CRAWL: begin
                sp = make_speeds($signed($urandom_range(0, 1024)) - 512,
                                 $signed($urandom_range(0, 1024)) - 512,
                                 $signed($urandom_range(0, 1024)) - 512,
                                 $signed($urandom_range(0, 1024)) - 512);
            end
            MIX_CORNER: begin
                sp = {corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                      corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]};
            end
            default: begin
                sp = {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
            end
        endcase
        return sp;
    endfunction

    // Random requests in bursts with gaps between them. Now and then the
    // sender holds off until every pose it asked for has come back.
    task automatic run_ticks(input int count, input bit flat_out);
        int            burst_left;
        int            gap;
        wheel_speeds_t sp;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 63) == 0) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                wait_drained();
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
            if (flat_out) begin
                // All four wheels equal: no turning, so one axis runs into its limit.
                sp = {4{SPEED_W'($urandom_range(30000, 32767))}};
            end else begin
                sp = random_speeds();
            end
            offer_tick(sp, 1'b0, '0);
        end
        s_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] radius, inv_track, period;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        verify_registers();

        // Directed script. With radius 65535, inverse track 1.0 and period
        // 512/65536, a spin of 25736 on each wheel turns by exactly a quarter
        // turn per tick without moving, so the heading walks through pi and
        // wraps back to zero while the position stays at the origin.
        add_tick(make_speeds(0, 0, 0, 0), 1'b1, pose_at_origin(0));
        add_write(REG_RADIUS, 32'hABCD_FFFF);
        add_write(REG_INV_TRACK, 32'h1234_0100);
        add_write(REG_PERIOD, 32'hFFFF_0200);
        add_tick(make_speeds(25736, 25736, -25736, -25736), 1'b1, pose_at_origin(16384));
        add_tick(make_speeds(25736, 25736, -25736, -25736), 1'b1, pose_at_origin(-32768));
        add_tick(make_speeds(25736, 25736, -25736, -25736), 1'b1, pose_at_origin(-16384));
        add_tick(make_speeds(25736, 25736, -25736, -25736), 1'b1, pose_at_origin(0));
        // A write to an unmapped index must leave the settings alone.
        add_write(REG_SPARE, 32'h0000_0000);
        add_tick(make_speeds(25736, 25736, -25736, -25736), 1'b1, pose_at_origin(16384));
        // A zero radius stops all motion and turning.
        add_write(REG_RADIUS, 32'h0000_0000);
        add_tick(make_speeds(32767, 32767, 32767, 32767), 1'b1, pose_at_origin(16384));
        add_tick(make_speeds(-32768, -32768, -32768, -32768), 1'b1, pose_at_origin(16384));
        // So does a zero period.
        add_write(REG_RADIUS, 32'h0000_FFFF);
        add_write(REG_PERIOD, 32'h0000_0000);
        add_tick(make_speeds(32767, -32768, 12345, -1), 1'b1, pose_at_origin(16384));
        // A zero inverse track moves without turning.
        add_write(REG_PERIOD, 32'h0000_FFFF);
        add_write(REG_INV_TRACK, 32'h0000_0000);
        add_tick(make_speeds(32767, 32767, -32768, -32768), 1'b0, '0);
        // Every register at its top: the largest steps in distance and angle.
        add_write(REG_INV_TRACK, 32'hFFFF_FFFF);
        add_tick(make_speeds(32767, 32767, 32767, 32767), 1'b0, '0);
        add_tick(make_speeds(-32768, -32768, -32768, -32768), 1'b0, '0);
        add_tick(make_speeds(32767, 32767, -32768, -32768), 1'b0, '0);
        add_tick(make_speeds(-32768, -32768, 32767, 32767), 1'b0, '0);
        add_tick(make_speeds(21845, -21846, 1, -1), 1'b0, '0);
        add_tick(make_speeds(-1, -1, -1, -1), 1'b0, '0);
        // Back to the reset settings for a gentle straight run and a curve.
        add_write(REG_RADIUS, {16'd0, RADIUS_RST});
        add_write(REG_INV_TRACK, {16'd0, INV_TRACK_RST});
        add_write(REG_PERIOD, {16'd0, PERIOD_RST});
        add_tick(make_speeds(256, 256, 256, 256), 1'b0, '0);
        add_tick(make_speeds(1000, 1200, -300, 700), 1'b0, '0);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                // Registers change only while nothing is in flight.
                s_valid <= 1'b0;
                @(posedge aclk);
                wait_drained();
                write_register(script[i].idx, script[i].wdata);
                verify_registers();
            end else begin
                offer_tick(script[i].speeds, script[i].typed, script[i].pose);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        // Flat-out straight driving at the top settings, long enough for the
        // path length and at least one axis to hit the positive limit.
        wait_drained();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_ticks(SATURATION_TICKS, 1'b1);
        @(posedge aclk);

        // Randomised phases, each under its own settings, the extremes first.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    radius = RADIUS_RST;  inv_track = INV_TRACK_RST; period = PERIOD_RST;
                end
                1: begin
                    radius = 16'd1;       inv_track = 16'd1;       period = 16'd1;
                end
                2: begin
                    radius = 16'hFFFF;    inv_track = 16'hFFFF;    period = 16'hFFFF;
                end
                3: begin
                    radius = 16'd0;       inv_track = INV_TRACK_RST; period = PERIOD_RST;
                end
                4: begin
                    radius = RADIUS_RST;  inv_track = 16'd0;       period = PERIOD_RST;
                end
                5: begin
                    radius = RADIUS_RST;  inv_track = INV_TRACK_RST; period = 16'd0;
                end
                6: begin
                    radius = 16'hFFFF;    inv_track = 16'd1;       period = 16'hFFFF;
                end
                7: begin
                    radius = 16'd1;       inv_track = 16'hFFFF;    period = 16'd1;
                end
                default: begin
                    radius    = 16'($urandom_range(1, 65535));
                    inv_track = 16'($urandom_range(1, 65535));
                    period    = 16'($urandom_range(1, 65535));
                end
            endcase
            wait_drained();
            load_settings(radius, inv_track, period);
            run_ticks(PHASE_TICKS, 1'b0);
            @(posedge aclk);
        end

        // Let the last poses come back, then give a stray result time to show.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
